// File: src/sbq_pkg.sv
// Shared types and constants for the stable sorted block queue.
package sbq_pkg;

   localparam int DEFAULT_QUEUE_DEPTH = 16;

   localparam int KEY_W    = 32;
   localparam int SIZE_W   = 24;
   localparam int HANDLE_W = 32;
   localparam int COUNT_W  = 5;

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_REMOVE = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic [KEY_W-1:0]    key;
      logic [SIZE_W-1:0]   size;
      logic [HANDLE_W-1:0] handle;
   } entry_type;

   typedef struct packed {
      logic             insert;
      logic             remove;
      logic [KEY_W-1:0] key;
   } cell_ctrl_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [KEY_W-1:0]    block_number;
      logic [SIZE_W-1:0]   block_size;
      logic [HANDLE_W-1:0] buffer_handle;
      logic [COUNT_W-1:0]  entry_count;
      logic                is_empty;
   } result_type;

endpackage

// File: src/sbq_cell.sv
// One slot of the sorted shift-register queue.
module sbq_cell (
   input  logic                  clock,
   input  sbq_pkg::cell_ctrl_type ctrl,
   input  sbq_pkg::entry_type    new_entry,
   input  logic                  occupied,
   input  sbq_pkg::entry_type    left_entry,
   input  logic                  left_shift,
   input  sbq_pkg::entry_type    right_entry,
   output sbq_pkg::entry_type    entry,
   output logic                  shift
);

   sbq_pkg::entry_type entry_ff;
   sbq_pkg::entry_type entry_in;

   // An empty slot counts as holding a larger key, so the insert lands in the first free slot.
   assign shift = occupied ? (entry_ff.key > ctrl.key) : 1'b1;
   assign entry = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      if (ctrl.insert && shift) begin
         entry_in = left_shift ? left_entry : new_entry;
      end else if (ctrl.remove) begin
         entry_in = right_entry;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// File: src/sbq_rsp_buf.sv
// Two-entry output buffer that decouples the request side from the response side.
module sbq_rsp_buf (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  sbq_pkg::result_type  push_data,
   output logic                 space,
   output logic                 out_valid,
   input  logic                 out_ready,
   output sbq_pkg::result_type  out_data
);

   logic                head_valid_ff, head_valid_in;
   logic                skid_valid_ff, skid_valid_in;
   sbq_pkg::result_type head_ff, head_in;
   sbq_pkg::result_type skid_ff, skid_in;
   logic                pop;
   logic                to_skid;

   assign pop       = head_valid_ff && out_ready;
   assign space     = !skid_valid_ff;
   assign out_valid = head_valid_ff;
   assign out_data  = head_ff;
   assign to_skid   = push && head_valid_ff && (skid_valid_ff || !pop);

   always_comb begin
      head_in = head_ff;
      skid_in = skid_ff;
      if (pop) begin
         head_in = skid_valid_ff ? skid_ff : push_data;
      end else if (!head_valid_ff) begin
         head_in = push_data;
      end
      if (to_skid) begin
         skid_in = push_data;
      end
      head_valid_in = push || skid_valid_ff || (head_valid_ff && !pop);
      if (to_skid) begin
         skid_valid_in = 1'b1;
      end else if (pop) begin
         skid_valid_in = 1'b0;
      end else begin
         skid_valid_in = skid_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= head_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      head_ff <= head_in;
      skid_ff <= skid_in;
   end

endmodule

// File: src/stable_sorted_block_queue.sv
// Top level of the stable sorted block queue.
// The queue keeps up to QUEUE_DEPTH blocks in a row of slots sorted by block number, head first;
// equal numbers keep arrival order. For every request (insert or remove), all slots compare
// the new key in parallel and shift by one position in the cycle it is accepted, so a
// request can be accepted on every cycle while responses are taken, and its response is
// presented on the next cycle. A two-entry output buffer takes in one more request while a
// response waits to be taken; with both entries held, req_ready stays low until one is taken.
module stable_sorted_block_queue #(
   parameter int QUEUE_DEPTH = sbq_pkg::DEFAULT_QUEUE_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_command,
   input  logic [sbq_pkg::KEY_W-1:0]     req_block_number,
   input  logic [sbq_pkg::SIZE_W-1:0]    req_block_size,
   input  logic [sbq_pkg::HANDLE_W-1:0]  req_buffer_handle,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [1:0]                    rsp_status,
   output logic [sbq_pkg::KEY_W-1:0]     rsp_out_block_number,
   output logic [sbq_pkg::SIZE_W-1:0]    rsp_out_block_size,
   output logic [sbq_pkg::HANDLE_W-1:0]  rsp_out_buffer_handle,
   output logic [sbq_pkg::COUNT_W-1:0]   rsp_entry_count,
   output logic                          rsp_is_empty
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [CNT_W-1:0]       count_ff, count_in;
   logic [CNT_W-1:0]       count_after;
   logic [CNT_W+sbq_pkg::COUNT_W-1:0] count_wide;
   logic                   accept;
   logic                   full;
   logic                   empty;
   logic                   space;
   sbq_pkg::cell_ctrl_type ctrl;
   sbq_pkg::entry_type     new_entry;
   sbq_pkg::entry_type     cell_entry [QUEUE_DEPTH];
   logic                   cell_shift [QUEUE_DEPTH];
   sbq_pkg::result_type    result;
   sbq_pkg::result_type    rsp_data;

   assign accept    = req_valid && req_ready;
   assign req_ready = space;
   assign full      = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign empty     = (count_ff == '0);

   assign new_entry.key    = req_block_number;
   assign new_entry.size   = req_block_size;
   assign new_entry.handle = req_buffer_handle;

   assign ctrl.insert = accept && (req_command == sbq_pkg::CMD_INSERT) && !full;
   assign ctrl.remove = accept && (req_command == sbq_pkg::CMD_REMOVE) && !empty;
   assign ctrl.key    = req_block_number;

   genvar gi;
   generate
      for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
         sbq_pkg::entry_type left_entry;
         sbq_pkg::entry_type right_entry;
         logic               left_shift;
         if (gi == 0) begin : g_first
            assign left_entry = new_entry;
            assign left_shift = 1'b0;
         end else begin : g_inner
            assign left_entry = cell_entry[gi-1];
            assign left_shift = cell_shift[gi-1];
         end
         if (gi == QUEUE_DEPTH - 1) begin : g_last
            assign right_entry = cell_entry[gi];
         end else begin : g_mid
            assign right_entry = cell_entry[gi+1];
         end
         sbq_cell u_cell (
            .clock       (clock),
            .ctrl        (ctrl),
            .new_entry   (new_entry),
            .occupied    (count_ff > CNT_W'(gi)),
            .left_entry  (left_entry),
            .left_shift  (left_shift),
            .right_entry (right_entry),
            .entry       (cell_entry[gi]),
            .shift       (cell_shift[gi])
         );
      end
   endgenerate

   always_comb begin
      count_in = count_ff;
      if (ctrl.insert) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.remove) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   assign count_after = count_in;
   assign count_wide  = {{sbq_pkg::COUNT_W{1'b0}}, count_after};

   always_comb begin
      result.status        = sbq_pkg::STATUS_OK;
      result.block_number  = '0;
      result.block_size    = '0;
      result.buffer_handle = '0;
      result.entry_count   = count_wide[sbq_pkg::COUNT_W-1:0];
      result.is_empty      = (count_after == '0);
      if (req_command == sbq_pkg::CMD_INSERT) begin
         if (full) begin
            result.status = sbq_pkg::STATUS_FULL;
         end
      end else if (empty) begin
         result.status = sbq_pkg::STATUS_EMPTY;
      end else begin
         result.block_number  = cell_entry[0].key;
         result.block_size    = cell_entry[0].size;
         result.buffer_handle = cell_entry[0].handle;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   sbq_rsp_buf u_rsp_buf (
      .clock     (clock),
      .reset     (reset),
      .push      (accept),
      .push_data (result),
      .space     (space),
      .out_valid (rsp_valid),
      .out_ready (rsp_ready),
      .out_data  (rsp_data)
   );

   assign rsp_status            = rsp_data.status;
   assign rsp_out_block_number  = rsp_data.block_number;
   assign rsp_out_block_size    = rsp_data.block_size;
   assign rsp_out_buffer_handle = rsp_data.buffer_handle;
   assign rsp_entry_count       = rsp_data.entry_count;
   assign rsp_is_empty          = rsp_data.is_empty;

endmodule

// File: src/sbq_checker.sv
// Port-level checks for the stable sorted block queue, bound to the top level.
module sbq_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [1:0]                    rsp_status,
   input logic [sbq_pkg::KEY_W-1:0]     rsp_out_block_number,
   input logic [sbq_pkg::SIZE_W-1:0]    rsp_out_block_size,
   input logic [sbq_pkg::HANDLE_W-1:0]  rsp_out_buffer_handle,
   input logic [sbq_pkg::COUNT_W-1:0]   rsp_entry_count,
   input logic                          rsp_is_empty
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_entry_count))
      else $error("Response changed while stalled.");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_is_empty == (rsp_entry_count == '0)))
      else $error("Empty flag disagrees with entry count.");

   a_full_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == sbq_pkg::STATUS_FULL) |->
         (rsp_out_block_number == '0) && (rsp_out_block_size == '0)
         && (rsp_out_buffer_handle == '0) && !rsp_is_empty)
      else $error("Rejected insert reports a removed entry or an empty queue.");

   a_empty_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == sbq_pkg::STATUS_EMPTY) |->
         rsp_is_empty && (rsp_out_block_number == '0) && (rsp_out_buffer_handle == '0))
      else $error("Remove from an empty queue reports data or entries.");

endmodule

bind stable_sorted_block_queue sbq_checker u_sbq_checker (.*);
